>>> rtl/tlpt_pkg.sv
package tlpt_pkg;

   localparam int unsigned DIR_IDX_W  = 10;
   localparam int unsigned TAB_IDX_W  = 10;
   localparam int unsigned OFFS_W     = 12;
   localparam int unsigned FRAME_W    = 20;
   localparam int unsigned DIR_DEPTH  = 1024;
   localparam int unsigned TAB_ROWS   = 1024;

   localparam logic [FRAME_W-1:0] RESET_BASE_FRAME = 20'd256;
   localparam logic [11:0] FLAG_P = 12'h001;
   localparam logic [11:0] FLAG_W = 12'h002;
   localparam logic [11:0] FLAG_U = 12'h004;
   localparam logic [32:0] PAGE_STEP = 33'd4096;
   localparam logic [32:0] OFFS_MASK = 33'h0_0000_0FFF;

   typedef enum logic [1:0] {
      ACT_ALLOC = 2'd0,
      ACT_MAP   = 2'd1,
      ACT_CHECK = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_REMAP      = 3'd1,
      ST_NOTABLE    = 3'd2,
      ST_NOTPRESENT = 3'd3,
      ST_OOM        = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_CLR_DIR,
      S_IDLE,
      S_DISPATCH,
      S_A_TEST,
      S_C_TEST,
      S_DIR_RD,
      S_DIR_CHK,
      S_TAB_CLR,
      S_TAB_RD,
      S_TAB_CHK,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic       load;
      logic       clr_dir;
      logic       dir_rd;
      logic       dir_use;
      logic       dir_alloc;
      logic       tab_clr;
      logic       tab_rd;
      logic       tab_wr;
      logic       take_frame;
      logic       advance;
      logic       set_res_va;
      logic       set_res_ext;
      logic       set_res_pte;
      logic       fail;
      status_type fail_code;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      action_type action;
      logic       shrink;
      logic       bound_done;
      logic       at_last;
      logic       dir_present;
      logic       tab_present;
      logic       slots_full;
      logic       frames_out;
      logic       clr_last;
      logic       first_page;
      logic       rsp_free;
   } stat_type;

endpackage

>>> rtl/two_level_page_table_mapper.sv
// Two-level page table mapper: allocates, maps and checks virtual ranges in a
// 1024-entry directory over up to MAX_TABLES page tables kept in on-chip RAM.
// After reset the directory is swept clear, one entry a cycle, before the
// first request is taken; csr writes are taken meanwhile.
// A map request passes through accept and dispatch, then per page a
// directory read and check and a table read and check or write, then
// finish. Alloc and check also test their bound before each page and once
// more at the end. A failing page ends the request early, and each page
// table created on first use adds a sweep that clears it.
// One request is in flight at a time; a finished response waits in an output
// register, so the next request may be taken while it is still pending. The
// finish cycle is held while an earlier response is still stalled.
module two_level_page_table_mapper #(
   parameter int unsigned MAX_TABLES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_virt_addr,
   input  logic [31:0] req_extent,
   input  logic [31:0] req_phys_addr,
   input  logic [11:0] req_perm,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_result_addr,
   input  logic        csr_write_enable,
   input  logic [19:0] csr_write_data
);
   import tlpt_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   tlpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tlpt_dp #(.MAX_TABLES(MAX_TABLES)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_action       (req_action),
      .req_virt_addr    (req_virt_addr),
      .req_extent       (req_extent),
      .req_phys_addr    (req_phys_addr),
      .req_perm         (req_perm),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_result_addr  (rsp_result_addr)
   );

endmodule

>>> rtl/tlpt_ctrl.sv
module tlpt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tlpt_pkg::stat_type stat,
   output tlpt_pkg::cmd_type  cmd
);
   import tlpt_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR_DIR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLR_DIR: if (stat.clr_last) state_in = S_IDLE;
         S_IDLE:    if (req_valid) state_in = S_DISPATCH;
         S_DISPATCH: begin
            unique case (stat.action)
               ACT_ALLOC: state_in = stat.shrink ? S_FINISH : S_A_TEST;
               ACT_MAP:   state_in = S_DIR_RD;
               ACT_CHECK: state_in = S_C_TEST;
               default:   state_in = S_FINISH;
            endcase
         end
         S_A_TEST: begin
            priority if (stat.bound_done) state_in = S_FINISH;
            else if (stat.frames_out) state_in = S_FINISH;
            else state_in = S_DIR_RD;
         end
         S_C_TEST:  state_in = stat.bound_done ? S_FINISH : S_DIR_RD;
         S_DIR_RD:  state_in = S_DIR_CHK;
         S_DIR_CHK: begin
            priority if (stat.dir_present) state_in = S_TAB_RD;
            else if (stat.action == ACT_CHECK) state_in = S_FINISH;
            else if (stat.slots_full || stat.frames_out) state_in = S_FINISH;
            else state_in = S_TAB_CLR;
         end
         S_TAB_CLR: if (stat.clr_last) state_in = S_TAB_RD;
         S_TAB_RD:  state_in = S_TAB_CHK;
         S_TAB_CHK: begin
            priority if (stat.action == ACT_CHECK) begin
               state_in = stat.tab_present ? S_C_TEST : S_FINISH;
            end else if (stat.tab_present) begin
               state_in = S_FINISH;
            end else if (stat.action == ACT_ALLOC) begin
               state_in = S_A_TEST;
            end else begin
               state_in = stat.at_last ? S_FINISH : S_DIR_RD;
            end
         end
         S_FINISH:  if (stat.rsp_free) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.fail_code = ST_OK;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLR_DIR: cmd.clr_dir = 1'b1;
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         S_DISPATCH: cmd.set_res_va = (stat.action == ACT_ALLOC) && stat.shrink;
         S_A_TEST: begin
            priority if (stat.bound_done) begin
               cmd.set_res_ext = 1'b1;
            end else if (stat.frames_out) begin
               cmd.fail      = 1'b1;
               cmd.fail_code = ST_OOM;
            end else begin
               cmd.take_frame = 1'b1;
            end
         end
         S_C_TEST: ;
         S_DIR_RD: cmd.dir_rd = 1'b1;
         S_DIR_CHK: begin
            priority if (stat.dir_present) begin
               cmd.dir_use = 1'b1;
            end else if (stat.action == ACT_CHECK) begin
               cmd.fail      = 1'b1;
               cmd.fail_code = ST_NOTABLE;
            end else if (stat.slots_full || stat.frames_out) begin
               cmd.fail      = 1'b1;
               cmd.fail_code = ST_OOM;
            end else begin
               cmd.dir_alloc = 1'b1;
            end
         end
         S_TAB_CLR: cmd.tab_clr = 1'b1;
         S_TAB_RD:  cmd.tab_rd = 1'b1;
         S_TAB_CHK: begin
            priority if (stat.action == ACT_CHECK) begin
               if (stat.tab_present) begin
                  cmd.advance     = 1'b1;
                  cmd.set_res_pte = stat.first_page;
               end else begin
                  cmd.fail      = 1'b1;
                  cmd.fail_code = ST_NOTPRESENT;
               end
            end else if (stat.tab_present) begin
               cmd.fail      = 1'b1;
               cmd.fail_code = ST_REMAP;
            end else begin
               cmd.tab_wr  = 1'b1;
               cmd.advance = 1'b1;
            end
         end
         S_FINISH: cmd.finish = stat.rsp_free;
         default: ;
      endcase
   end

endmodule

>>> rtl/tlpt_dp.sv
module tlpt_dp #(
   parameter int unsigned MAX_TABLES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         req_action,
   input  logic [31:0]        req_virt_addr,
   input  logic [31:0]        req_extent,
   input  logic [31:0]        req_phys_addr,
   input  logic [11:0]        req_perm,
   input  logic               csr_write_enable,
   input  logic [19:0]        csr_write_data,
   input  tlpt_pkg::cmd_type  cmd,
   output tlpt_pkg::stat_type stat,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic [31:0]        rsp_result_addr
);
   import tlpt_pkg::*;

   localparam int unsigned SLOT_W     = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
   localparam int unsigned USED_W     = $clog2(MAX_TABLES + 1);
   localparam int unsigned TAB_DEPTH  = MAX_TABLES * TAB_ROWS;
   localparam logic [USED_W-1:0] USED_MAX = USED_W'(MAX_TABLES);

   logic [SLOT_W:0]  dir_mem [DIR_DEPTH];
   logic [31:0]      tab_mem [TAB_DEPTH];

   action_type       action_ff;
   logic [31:0]      va_ff, ext_ff, addr_ff, last_ff, pa_ff;
   logic [11:0]      perm_ff;
   logic [32:0]      bound_ff;
   status_type       status_ff;
   logic [31:0]      result_ff;
   logic [FRAME_W-1:0] next_frame_ff;
   logic [USED_W-1:0] used_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [TAB_IDX_W-1:0] clr_cnt_ff;
   logic [SLOT_W:0]  dir_q_ff;
   logic [31:0]      tab_q_ff;
   logic             rsp_valid_ff;
   status_type       rsp_status_ff;
   logic [31:0]      rsp_result_ff;

   logic [32:0]      roundup;
   logic [31:0]      last_in;
   logic [DIR_IDX_W-1:0] dir_idx;
   logic [SLOT_W+TAB_IDX_W-1:0] tab_wr_addr, tab_clr_addr;

   assign roundup      = ({1'b0, req_virt_addr} + OFFS_MASK) & ~OFFS_MASK;
   assign last_in      = (req_virt_addr + req_extent - 32'd1) & ~OFFS_MASK[31:0];
   assign dir_idx      = addr_ff[31:22];
   assign tab_wr_addr  = {slot_ff, addr_ff[21:12]};
   assign tab_clr_addr = {slot_ff, clr_cnt_ff};

   // directory: present bit over table slot
   always_ff @(posedge clock) begin
      if (cmd.clr_dir) begin
         dir_mem[clr_cnt_ff] <= '0;
      end else if (cmd.dir_alloc) begin
         dir_mem[dir_idx] <= {1'b1, used_ff[SLOT_W-1:0]};
      end
      if (cmd.dir_rd) begin
         dir_q_ff <= dir_mem[dir_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tab_clr) begin
         tab_mem[tab_clr_addr] <= '0;
      end else if (cmd.tab_wr) begin
         tab_mem[tab_wr_addr] <= pa_ff | {20'd0, perm_ff} | {20'd0, FLAG_P};
      end
      if (cmd.tab_rd) begin
         tab_q_ff <= tab_mem[tab_wr_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_frame_ff <= RESET_BASE_FRAME + 20'd1;
         used_ff       <= '0;
         clr_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            next_frame_ff <= csr_write_data + 20'd1;
         end else if (cmd.take_frame || cmd.dir_alloc) begin
            next_frame_ff <= next_frame_ff + 20'd1;
         end
         if (cmd.dir_alloc) begin
            used_ff <= used_ff + USED_W'(1);
         end
         if (cmd.clr_dir || cmd.tab_clr) begin
            clr_cnt_ff <= clr_cnt_ff + TAB_IDX_W'(1);
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= action_type'(req_action);
         va_ff     <= req_virt_addr;
         ext_ff    <= req_extent;
         last_ff   <= last_in;
         pa_ff     <= req_phys_addr;
         status_ff <= ST_OK;
         result_ff <= '0;
         if (action_type'(req_action) == ACT_ALLOC) begin
            perm_ff  <= FLAG_W | FLAG_U;
            addr_ff  <= roundup[31:0];
            bound_ff <= roundup;
         end else begin
            perm_ff  <= req_perm;
            addr_ff  <= (action_type'(req_action) == ACT_MAP)
                        ? (req_virt_addr & ~OFFS_MASK[31:0]) : req_virt_addr;
            bound_ff <= '0;
         end
      end else begin
         if (cmd.take_frame) begin
            pa_ff <= {next_frame_ff, 12'd0};
         end
         if (cmd.advance) begin
            addr_ff  <= addr_ff + PAGE_STEP[31:0];
            pa_ff    <= pa_ff + PAGE_STEP[31:0];
            bound_ff <= bound_ff + PAGE_STEP;
         end
         if (cmd.fail) begin
            status_ff <= cmd.fail_code;
            result_ff <= '0;
         end else if (cmd.set_res_va) begin
            result_ff <= va_ff;
         end else if (cmd.set_res_ext) begin
            result_ff <= ext_ff;
         end else if (cmd.set_res_pte) begin
            result_ff <= {tab_q_ff[31:12], 12'd0};
         end
      end
      if (cmd.dir_alloc) begin
         slot_ff <= used_ff[SLOT_W-1:0];
      end else if (cmd.dir_use) begin
         slot_ff <= dir_q_ff[SLOT_W-1:0];
      end
      if (cmd.finish) begin
         rsp_status_ff <= status_ff;
         rsp_result_ff <= result_ff;
      end
   end

   always_comb begin
      stat.action      = action_ff;
      stat.shrink      = ext_ff < va_ff;
      stat.bound_done  = !(bound_ff < {1'b0, ext_ff});
      stat.at_last     = addr_ff == last_ff;
      stat.dir_present = dir_q_ff[SLOT_W];
      stat.tab_present = tab_q_ff[0];
      stat.slots_full  = used_ff >= USED_MAX;
      stat.frames_out  = next_frame_ff == '0;
      stat.clr_last    = &clr_cnt_ff;
      stat.first_page  = bound_ff == '0;
      stat.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_result_addr = rsp_result_ff;

endmodule

>>> rtl/tlpt_checker.sv
module tlpt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [31:0] rsp_result_addr
);
   import tlpt_pkg::*;

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                  && $stable(rsp_result_addr))
      else $error("response changed while stalled");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_result_addr == 32'd0)
      else $error("failed response carries an address");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_OOM)
      else $error("unknown status code");

   // directory sweep follows reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("ready during directory clear");

endmodule

bind two_level_page_table_mapper tlpt_checker u_tlpt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_result_addr (rsp_result_addr)
);

>>> tb/sv/two_level_page_table_mapper_test.sv
`timescale 1ns / 1ps

module two_level_page_table_mapper_test;
   import tlpt_pkg::*;

   localparam int unsigned NUM_TABLES = 16;
   localparam int unsigned STALL_LIMIT = 400000;

   typedef struct {
      action_type  action;
      logic [31:0] va;
      logic [31:0] ext;
      logic [31:0] pa;
      logic [11:0] perm;
   } page_req_type;

   typedef struct {
      status_type  status;
      logic [31:0] addr;
   } page_rsp_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_action;
   logic [31:0] req_virt_addr;
   logic [31:0] req_extent;
   logic [31:0] req_phys_addr;
   logic [11:0] req_perm;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_result_addr;
   logic        csr_write_enable;
   logic [19:0] csr_write_data;

   page_req_type pending_reqs[$];
   page_rsp_type expected_rsps[$];
   int        send_idle_pct;
   int        recv_stall_pct;
   int        mismatches;
   int        quiet_cycles;

   // shadow page-table state
   logic [31:0]  sh_dir[DIR_DEPTH];
   logic [3:0]   sh_slot[DIR_DEPTH];
   logic [31:0]  sh_pte[NUM_TABLES * TAB_ROWS];
   logic [19:0]  sh_next_frame;
   int unsigned  sh_tables_used;
   logic [31:0]  dir_pool[24];

   two_level_page_table_mapper #(.MAX_TABLES(NUM_TABLES)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_virt_addr(req_virt_addr),
      .req_extent(req_extent),
      .req_phys_addr(req_phys_addr),
      .req_perm(req_perm),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_result_addr(rsp_result_addr),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void queue_req(input page_req_type r);
      pending_reqs.insert(pending_reqs.size(), r);
   endfunction

   function automatic bit grab_frame(output logic [19:0] frame);
      if (sh_next_frame == 20'd0) return 1'b0;
      frame = sh_next_frame;
      sh_next_frame = sh_next_frame + 20'd1;
      return 1'b1;
   endfunction

   function automatic int pte_slot(input logic [31:0] va);
      return int'(sh_slot[va[31:22]]) * TAB_ROWS + int'(va[21:12]);
   endfunction

   function automatic status_type walk_or_create(input logic [31:0] va, output int idx);
      logic [19:0] frame;
      if (!sh_dir[va[31:22]][0]) begin
         if (sh_tables_used >= NUM_TABLES) return ST_OOM;
         if (!grab_frame(frame)) return ST_OOM;
         sh_slot[va[31:22]] = sh_tables_used[3:0];
         sh_tables_used++;
         sh_dir[va[31:22]] = {frame, 12'h000} | {20'd0, FLAG_P | FLAG_W | FLAG_U};
      end
      idx = pte_slot(va);
      return ST_OK;
   endfunction

   function automatic status_type map_range(input logic [31:0] va, input logic [31:0] size,
                                            input logic [31:0] pa, input logic [11:0] perm);
      logic [31:0] a;
      logic [31:0] last;
      status_type  st;
      int          idx;
      a = va & ~32'hFFF;
      last = (va + size - 32'd1) & ~32'hFFF;
      forever begin
         st = walk_or_create(a, idx);
         if (st != ST_OK) return st;
         if (sh_pte[idx][0]) return ST_REMAP;
         sh_pte[idx] = pa | {20'd0, perm} | {20'd0, FLAG_P};
         if (a == last) break;
         a += 32'd4096;
         pa += 32'd4096;
      end
      return ST_OK;
   endfunction

   function automatic page_rsp_type predict_rsp(input page_req_type r);
      page_rsp_type o;
      logic [63:0] a;
      logic [63:0] i;
      logic [19:0] frame;
      logic [31:0] v;
      logic [31:0] pte;
      o.status = ST_OK;
      o.addr = 32'd0;
      case (r.action)
         ACT_ALLOC: begin
            if (r.ext < r.va) begin
               o.addr = r.va;
            end else begin
               a = ({32'd0, r.va} + 64'hFFF) & ~64'hFFF;
               o.addr = r.ext;
               for (; a < {32'd0, r.ext}; a += 64'd4096) begin
                  if (!grab_frame(frame)) begin
                     o.status = ST_OOM;
                     break;
                  end
                  o.status = map_range(a[31:0], 32'd4096, {frame, 12'h000},
                                       FLAG_W | FLAG_U);
                  if (o.status != ST_OK) break;
               end
               if (o.status != ST_OK) o.addr = 32'd0;
            end
         end
         ACT_MAP: o.status = map_range(r.va, r.ext, r.pa, r.perm);
         ACT_CHECK: begin
            for (i = 0; i < {32'd0, r.ext}; i += 64'd4096) begin
               v = r.va + i[31:0];
               if (!sh_dir[v[31:22]][0]) begin
                  o.status = ST_NOTABLE;
                  break;
               end
               pte = sh_pte[pte_slot(v)];
               if (!pte[0]) begin
                  o.status = ST_NOTPRESENT;
                  break;
               end
               if (i == 0) o.addr = pte & ~32'hFFF;
            end
            if (o.status != ST_OK) o.addr = 32'd0;
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic page_req_type make_req(input action_type act, input logic [31:0] va,
                                             input logic [31:0] ext, input logic [31:0] pa,
                                             input logic [11:0] perm);
      page_req_type r;
      r.action = act;
      r.va = va;
      r.ext = ext;
      r.pa = pa;
      r.perm = perm;
      return r;
   endfunction

   // well-formed beats stay in a pool of directories so that tables fill and hits repeat
   function automatic page_req_type random_req();
      page_req_type r;
      logic [31:0] base;
      int          pick;
      base = dir_pool[$urandom_range(23)] | {10'd0, 4'd0, 6'($urandom_range(63)), 12'd0};
      base[11:0] = 12'($urandom);
      r = make_req(ACT_NONE, $urandom, 32'($urandom_range(1, 8 * 4096)), $urandom,
                   12'($urandom));
      pick = $urandom_range(99);
      if (pick < 8) begin
         r.action = action_type'($urandom_range(3));
         r.va = $urandom;
         r.ext = (r.action == ACT_CHECK) ? 32'($urandom) : 32'($urandom_range(0, 65535));
         if (r.action == ACT_ALLOC) r.ext = r.va + 32'($urandom_range(0, 5 * 4096));
         if (r.action == ACT_MAP && r.ext == 0) r.ext = 32'd1;
      end else if (pick < 36) begin
         r.action = ACT_ALLOC;
         r.va = base;
         r.ext = ($urandom_range(9) == 0) ? base - 32'($urandom_range(1, 4096))
                                          : base + 32'($urandom_range(0, 6 * 4096));
      end else if (pick < 64) begin
         r.action = ACT_MAP;
         r.va = base;
      end else if (pick < 96) begin
         r.action = ACT_CHECK;
         r.va = base;
         if ($urandom_range(19) == 0) r.ext = 32'd0;
      end else begin
         r.action = ACT_NONE;
      end
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      page_req_type r;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            r = make_req(action_type'(req_action), req_virt_addr, req_extent,
                         req_phys_addr, req_perm);
            expected_rsps.insert(expected_rsps.size(), predict_rsp(r));
         end
         if (!req_valid || req_ready) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               r = pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_action <= r.action;
               req_virt_addr <= r.va;
               req_extent <= r.ext;
               req_phys_addr <= r.pa;
               req_perm <= r.perm;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      page_rsp_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response beat: status %0d addr %h",
                           rsp_status, rsp_result_addr);
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_status !== e.status || rsp_result_addr !== e.addr) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("response mismatch: expected status %0d addr %h, got %0d %h",
                              e.status, e.addr, rsp_status, rsp_result_addr);
               end
            end
         end
      end
   end

   // watchdog; cleared by any accepted beat
   always @(posedge clock) begin
      if (!reset) begin
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("two_level_page_table_mapper_test: done, errors");
            $finish;
         end
      end
   end

   task automatic write_base(input logic [19:0] frame);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= frame;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sh_next_frame = frame + 20'd1;
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic run_random(input int count);
      repeat (count) queue_req(random_req());
      drain();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = ACT_ALLOC;
      req_virt_addr = '0;
      req_extent = '0;
      req_phys_addr = '0;
      req_perm = '0;
      rsp_ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      mismatches = 0;
      quiet_cycles = 0;
      send_idle_pct = 6;
      recv_stall_pct = 79;
      foreach (sh_dir[i]) begin
         sh_dir[i] = '0;
         sh_slot[i] = '0;
      end
      foreach (sh_pte[i]) sh_pte[i] = '0;
      sh_next_frame = RESET_BASE_FRAME + 20'd1;
      sh_tables_used = 0;
      dir_pool[0] = 32'h0000_0000;
      dir_pool[1] = 32'hFFC0_0000;
      for (int i = 2; i < 24; i++) dir_pool[i] = {10'($urandom), 22'd0};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      write_base(20'h00100);
      queue_req(make_req(ACT_ALLOC, 32'h0, 32'h3000, 32'h0, 12'h0));
      queue_req(make_req(ACT_ALLOC, 32'h5000, 32'h1000, 32'h0, 12'hFFF));
      // rounding up past the top maps nothing
      queue_req(make_req(ACT_ALLOC, 32'hFFFF_F001, 32'hFFFF_FFFF, 32'h0, 12'h0));
      queue_req(make_req(ACT_ALLOC, 32'hFFFF_E000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF));
      queue_req(make_req(ACT_CHECK, 32'h0, 32'h3000, 32'h0, 12'h0));
      queue_req(make_req(ACT_CHECK, 32'h1234, 32'h0, 32'h0, 12'h0));
      queue_req(make_req(ACT_CHECK, 32'h0080_0000, 32'h1000, 32'h0, 12'h0));
      queue_req(make_req(ACT_CHECK, 32'h0000_5000, 32'h1000, 32'h0, 12'h0));
      queue_req(make_req(ACT_MAP, 32'h0040_0000, 32'h2000, 32'hABCD_E123, 12'hFFF));
      queue_req(make_req(ACT_MAP, 32'h0040_0000, 32'h1000, 32'h0, 12'h0));
      // zero length wraps, but the next page is already mapped
      queue_req(make_req(ACT_MAP, 32'h0040_1000, 32'h0, 32'h0, 12'h0));
      queue_req(make_req(ACT_CHECK, 32'h0040_0000, 32'h2000, 32'h0, 12'h0));
      queue_req(make_req(ACT_CHECK, 32'hFFFF_F000, 32'h2000, 32'h0, 12'h0));
      queue_req(make_req(ACT_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 12'h0));
      queue_req(make_req(ACT_MAP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_F000, 12'h0));
      queue_req(make_req(ACT_MAP, 32'h0000_3000, 32'h1, 32'h0, 12'h0));
      queue_req(make_req(ACT_CHECK, 32'h0000_3000, 32'h1, 32'h0, 12'h0));
      queue_req(make_req(ACT_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF));
      queue_req(make_req(ACT_NONE, 32'h0, 32'h0, 32'h0, 12'h0));
      drain();

      write_base(20'h00000);
      run_random(380);

      send_idle_pct = 79;
      recv_stall_pct = 6;
      // only a handful of frames before the allocator wraps to zero
      write_base(20'hFFFF8);
      run_random(380);

      send_idle_pct = 0;
      recv_stall_pct = 0;
      write_base(20'hFFFFF);
      run_random(10);
      write_base(20'h4A5C3);
      run_random(380);

      if (mismatches == 0) begin
         $display("two_level_page_table_mapper_test: done, clean");
      end else begin
         $display("two_level_page_table_mapper_test: done, errors");
      end
      $finish;
   end

endmodule
